FILE: rtl/ccp_pkg.sv
// shared types and constants for the cylinder containment and projection block
`default_nettype none
package ccp_pkg;

	localparam int CW = 32;              // coordinate width, Q16.16
	localparam int SQ_STEPS = CW;        // one root bit per sqrt stage
	localparam int DIV_STEPS = CW;       // one quotient bit per divide stage
	localparam int QDEPTH = 2;           // entries in the front-to-back queue
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [CW-2:0] umag_t;
	typedef logic [2*CW-1:0] wide_t;
	typedef logic signed [CW+1:0] ext_t;

	// configuration register indexes
	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_BOTTOM = 2'd1;
	localparam logic [1:0] CFG_TOP = 2'd2;

	typedef struct packed {
		umag_t radius;
		coord_t bottom;
		coord_t top;
	} cyl_cfg_t;

	// classified point handed from front to back
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t pz;
		logic in_z;
		logic within_r;
		logic is_inside;
		logic fully_inside;
		logic [CW-1:0] n;
	} front_item_t;

	// per-stage control carried through the divider
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t pz;
		logic side;
		logic axis;
		logic is_inside;
		logic fully_inside;
		logic [CW-1:0] n;
	} back_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/ccp_front.sv
// front pipeline: squares, containment tests, z clamp and radial square root
`default_nettype none
module ccp_front import ccp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cyl_cfg_t    cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire coord_t      point_x,
	input  wire coord_t      point_y,
	input  wire coord_t      point_z,
	input  wire umag_t       margin,
	output logic             out_valid,
	input  wire logic        out_ready,
	output front_item_t      out_item
);

	logic adv;

	logic v_s1, v_s2;
	coord_t x_s1, y_s1, z_s1;
	umag_t m_s1;

	wide_t ax2_s2, ay2_s2, r2_s2, rm2_s2;
	logic mfit_s2, gt_s2, lt_s2;
	coord_t x_s2, y_s2, z_s2, pz_s2;

	logic v_s [0:SQ_STEPS];
	front_item_t itm_s [0:SQ_STEPS];
	wide_t rem_s [0:SQ_STEPS];
	logic [CW-1:0] root_s [0:SQ_STEPS];

	logic [CW-1:0] ax, ay;
	umag_t rm;
	ext_t zx, mx;
	logic mfit;
	wide_t s_sum;

	wide_t rem_nx [0:SQ_STEPS-1];
	logic [CW-1:0] root_nx [0:SQ_STEPS-1];

	// whole front moves when its last stage is empty or the queue takes it
	assign adv = !v_s[SQ_STEPS] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_s[SQ_STEPS];

	always_comb begin
		out_item = itm_s[SQ_STEPS];
		out_item.n = root_s[SQ_STEPS];
	end

	// magnitudes and margin tests
	always_comb begin
		ax = x_s1[CW-1] ? CW'(-x_s1) : CW'(x_s1);
		ay = y_s1[CW-1] ? CW'(-y_s1) : CW'(y_s1);
		rm = cfg.radius - m_s1;
		zx = ext_t'(z_s1);
		mx = ext_t'(m_s1);
		mfit = (m_s1 <= cfg.radius) && (zx - mx >= ext_t'(cfg.bottom))
			&& (zx + mx <= ext_t'(cfg.top));
	end

	assign s_sum = ax2_s2 + ay2_s2;

	// sqrt digit recurrence, one root bit per stage
	always_comb begin
		wide_t trial;
		for (int k = 0; k < SQ_STEPS; k++) begin
			trial = (wide_t'(root_s[k]) << (SQ_STEPS - k))
				| (wide_t'(1) << (2 * (SQ_STEPS - 1 - k)));
			if (trial <= rem_s[k]) begin
				rem_nx[k] = rem_s[k] - trial;
				root_nx[k] = root_s[k] | (CW'(1) << (SQ_STEPS - 1 - k));
			end else begin
				rem_nx[k] = rem_s[k];
				root_nx[k] = root_s[k];
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
			for (int k = 0; k < SQ_STEPS; k++) v_s[k+1] <= v_s[k];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= point_x;
			y_s1 <= point_y;
			z_s1 <= point_z;
			m_s1 <= margin;

			ax2_s2 <= wide_t'(ax) * wide_t'(ax);
			ay2_s2 <= wide_t'(ay) * wide_t'(ay);
			r2_s2 <= wide_t'(cfg.radius) * wide_t'(cfg.radius);
			rm2_s2 <= wide_t'(rm) * wide_t'(rm);
			mfit_s2 <= mfit;
			gt_s2 <= z_s1 > cfg.top;
			lt_s2 <= z_s1 < cfg.bottom;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
			pz_s2 <= (z_s1 > cfg.top) ? cfg.top : (z_s1 < cfg.bottom) ? cfg.bottom : z_s1;

			itm_s[0].x <= x_s2;
			itm_s[0].y <= y_s2;
			itm_s[0].z <= z_s2;
			itm_s[0].pz <= pz_s2;
			itm_s[0].in_z <= !gt_s2 && !lt_s2;
			itm_s[0].within_r <= s_sum <= r2_s2;
			itm_s[0].is_inside <= !gt_s2 && !lt_s2 && (s_sum <= r2_s2);
			itm_s[0].fully_inside <= mfit_s2 && (s_sum <= rm2_s2);
			itm_s[0].n <= '0;
			rem_s[0] <= s_sum;
			root_s[0] <= '0;

			for (int k = 0; k < SQ_STEPS; k++) begin
				itm_s[k+1] <= itm_s[k];
				rem_s[k+1] <= rem_nx[k];
				root_s[k+1] <= root_nx[k];
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ccp_queue.sv
// short queue between front and back pipelines
`default_nettype none
module ccp_queue import ccp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	output logic             push_ready,
	input  wire front_item_t push_item,
	output logic             pop_valid,
	input  wire logic        pop_ready,
	output front_item_t      pop_item
);

	front_item_t mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid = count_q != '0;
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

FILE: rtl/ccp_back.sv
// back pipeline: surface choice, radial scaling divide and result register
`default_nettype none
module ccp_back import ccp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cyl_cfg_t    cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire front_item_t in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_inside,
	output logic             fully_inside,
	output coord_t           proj_x,
	output coord_t           proj_y,
	output coord_t           proj_z
);

	logic adv;
	logic out_valid_q;

	logic v_s [0:DIV_STEPS];
	back_ctl_t ctl_s [0:DIV_STEPS];
	wide_t remx_s [0:DIV_STEPS];
	wide_t remy_s [0:DIV_STEPS];
	logic [CW-1:0] qx_s [0:DIV_STEPS];
	logic [CW-1:0] qy_s [0:DIV_STEPS];

	wide_t remx_nx [0:DIV_STEPS-1];
	wide_t remy_nx [0:DIV_STEPS-1];
	logic [CW-1:0] qx_nx [0:DIV_STEPS-1];
	logic [CW-1:0] qy_nx [0:DIV_STEPS-1];

	back_ctl_t ctl0;
	logic [CW-1:0] ax, ay;
	ext_t gap, to_top, to_bot;

	logic is_inside_q, fully_inside_q;
	coord_t proj_x_q, proj_y_q, proj_z_q;
	coord_t px, py;
	back_ctl_t ctl_l;

	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign out_valid = out_valid_q;
	assign is_inside = is_inside_q;
	assign fully_inside = fully_inside_q;
	assign proj_x = proj_x_q;
	assign proj_y = proj_y_q;
	assign proj_z = proj_z_q;

	// pick side or cap for the projection
	always_comb begin
		ax = in_item.x[CW-1] ? CW'(-in_item.x) : CW'(in_item.x);
		ay = in_item.y[CW-1] ? CW'(-in_item.y) : CW'(in_item.y);
		gap = ext_t'(cfg.radius) - ext_t'(in_item.n);
		to_top = ext_t'(cfg.top) - ext_t'(in_item.z);
		to_bot = ext_t'(in_item.z) - ext_t'(cfg.bottom);
		ctl0.x = in_item.x;
		ctl0.y = in_item.y;
		ctl0.pz = in_item.pz;
		ctl0.side = 1'b0;
		ctl0.axis = in_item.n == '0;
		ctl0.is_inside = in_item.is_inside;
		ctl0.fully_inside = in_item.fully_inside;
		ctl0.n = in_item.n;
		priority if (!in_item.within_r) begin
			ctl0.side = 1'b1;
		end else if (in_item.in_z) begin
			priority if (to_top < gap) ctl0.pz = cfg.top;
			else if (to_bot < gap) ctl0.pz = cfg.bottom;
			else ctl0.side = 1'b1;
		end else begin
			// inside the radius but past a cap: keep x and y
			ctl0.side = 1'b0;
		end
	end

	// restoring divide, one quotient bit per stage
	always_comb begin
		wide_t dv;
		for (int k = 0; k < DIV_STEPS; k++) begin
			dv = wide_t'(ctl_s[k].n) << (DIV_STEPS - 1 - k);
			if (remx_s[k] >= dv) begin
				remx_nx[k] = remx_s[k] - dv;
				qx_nx[k] = qx_s[k] | (CW'(1) << (DIV_STEPS - 1 - k));
			end else begin
				remx_nx[k] = remx_s[k];
				qx_nx[k] = qx_s[k];
			end
			if (remy_s[k] >= dv) begin
				remy_nx[k] = remy_s[k] - dv;
				qy_nx[k] = qy_s[k] | (CW'(1) << (DIV_STEPS - 1 - k));
			end else begin
				remy_nx[k] = remy_s[k];
				qy_nx[k] = qy_s[k];
			end
		end
	end

	// final selection with sign restore
	always_comb begin
		ctl_l = ctl_s[DIV_STEPS];
		if (!ctl_l.side) begin
			px = ctl_l.x;
			py = ctl_l.y;
		end else if (ctl_l.axis) begin
			px = coord_t'(cfg.radius);
			py = '0;
		end else begin
			px = ctl_l.x[CW-1] ? -coord_t'(qx_s[DIV_STEPS]) : coord_t'(qx_s[DIV_STEPS]);
			py = ctl_l.y[CW-1] ? -coord_t'(qy_s[DIV_STEPS]) : coord_t'(qy_s[DIV_STEPS]);
		end
	end

	// stage valid bits and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) v_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
			for (int k = 0; k < DIV_STEPS; k++) v_s[k+1] <= v_s[k];
			out_valid_q <= v_s[DIV_STEPS];
		end
	end

	// stage payload and result register
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0] <= ctl0;
			remx_s[0] <= wide_t'(ax) * wide_t'(cfg.radius);
			remy_s[0] <= wide_t'(ay) * wide_t'(cfg.radius);
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			for (int k = 0; k < DIV_STEPS; k++) begin
				ctl_s[k+1] <= ctl_s[k];
				remx_s[k+1] <= remx_nx[k];
				remy_s[k+1] <= remy_nx[k];
				qx_s[k+1] <= qx_nx[k];
				qy_s[k+1] <= qy_nx[k];
			end
			is_inside_q <= ctl_l.is_inside;
			fully_inside_q <= ctl_l.fully_inside;
			proj_x_q <= px;
			proj_y_q <= py;
			proj_z_q <= ctl_l.pz;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cylinder_containment_and_projection.sv
// top level: configuration registers, front pipeline, queue and back pipeline
// front: squares, tests and 32 sqrt stages; then the queue; back: 32 divide
// stages and the result register; sqrt and divider take one bit per stage
// throughput: one point per cycle unless out_ready stalls the output
// reset: arst_n clears configuration to zero and empties all stages and the queue
`default_nettype none
module cylinder_containment_and_projection import ccp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [CW-1:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire coord_t      point_x,
	input  wire coord_t      point_y,
	input  wire coord_t      point_z,
	input  wire umag_t       margin,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_inside,
	output logic             fully_inside,
	output coord_t           proj_x,
	output coord_t           proj_y,
	output coord_t           proj_z
);

	cyl_cfg_t cfg_q;
	logic f_valid, f_ready, b_valid, b_ready;
	front_item_t f_item, b_item;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RADIUS: cfg_q.radius <= cfg_data[CW-2:0];
				CFG_BOTTOM: cfg_q.bottom <= coord_t'(cfg_data);
				CFG_TOP: cfg_q.top <= coord_t'(cfg_data);
				default: ;
			endcase
		end
	end

	ccp_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z), .margin(margin),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	ccp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
		.pop_valid(b_valid), .pop_ready(b_ready), .pop_item(b_item)
	);

	ccp_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_inside(is_inside), .fully_inside(fully_inside),
		.proj_x(proj_x), .proj_y(proj_y), .proj_z(proj_z)
	);

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench for the cylinder containment and projection block
`timescale 1ns / 1ps
module testbench;
	import ccp_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 80;
	localparam int RAND_PHASES = 4;
	localparam int PHASE_ITEMS = 250;
	localparam int NROWS = 15;

	typedef struct {
		logic is_inside;
		logic fully_inside;
		coord_t px;
		coord_t py;
		coord_t pz;
	} surf_hit_t;

	typedef struct {
		bit load_cfg;
		logic [CW-1:0] radius;
		logic [CW-1:0] bottom;
		logic [CW-1:0] top;
		coord_t x;
		coord_t y;
		coord_t z;
		umag_t m;
		bit typed;
		surf_hit_t hit;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [CW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	umag_t margin;
	logic out_valid;
	logic out_ready;
	logic is_inside;
	logic fully_inside;
	coord_t proj_x;
	coord_t proj_y;
	coord_t proj_z;

	// cylinder as the predictor sees it
	longint cyl_rad;
	longint cyl_bot;
	longint cyl_top;

	surf_hit_t hits_due[$];
	point_row_t rows[NROWS];
	int send_idle;
	int recv_idle;
	int errors = 0;
	int cycles = 0;

	cylinder_containment_and_projection dut (.*);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// nearest surface point and containment for one point
	function automatic surf_hit_t project_point(coord_t x, coord_t y, coord_t z, umag_t m);
		longint sx, sy, sz, mm, gap, px, py, pz;
		logic [127:0] ax, ay, s, r2, rm, c, q;
		logic [63:0] n, cand;
		bit within_rad, in_z, side, full;
		surf_hit_t h;
		sx = x;
		sy = y;
		sz = z;
		mm = m;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		s = ax * ax + ay * ay;
		r2 = 128'(cyl_rad) * 128'(cyl_rad);
		within_rad = s <= r2;
		h.is_inside = sz >= cyl_bot && sz <= cyl_top && within_rad;
		full = mm <= cyl_rad;
		if (full && sz - mm < cyl_bot)
			full = 0;
		if (full && sz + mm > cyl_top)
			full = 0;
		if (full) begin
			rm = 128'(cyl_rad - mm);
			full = s <= rm * rm;
		end
		h.fully_inside = full;
		px = sx;
		py = sy;
		pz = sz;
		in_z = 1;
		side = 0;
		if (sz > cyl_top) begin
			pz = cyl_top;
			in_z = 0;
		end else if (sz < cyl_bot) begin
			pz = cyl_bot;
			in_z = 0;
		end
		// integer square root of the radial distance squared
		n = 0;
		for (int b = 52; b >= 0; b--) begin
			cand = n | (64'd1 << b);
			c = 128'(cand) * 128'(cand);
			if (c <= s)
				n = cand;
		end
		if (!within_rad) begin
			side = 1;
		end else if (in_z) begin
			gap = cyl_rad - longint'(n);
			if (cyl_top - sz < gap)
				pz = cyl_top;
			else if (sz - cyl_bot < gap)
				pz = cyl_bot;
			else
				side = 1;
		end
		// snap to the side wall, (radius, 0) on the axis
		if (side) begin
			if (n == 0) begin
				px = cyl_rad;
				py = 0;
			end else begin
				q = (ax * 128'(cyl_rad)) / 128'(n);
				px = (sx < 0) ? -longint'(q) : longint'(q);
				q = (ay * 128'(cyl_rad)) / 128'(n);
				py = (sy < 0) ? -longint'(q) : longint'(q);
			end
		end
		h.px = px[CW-1:0];
		h.py = py[CW-1:0];
		h.pz = pz[CW-1:0];
		return h;
	endfunction

	// register write, predictor copy kept in step; enable left high for the next write
	task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_RADIUS: cyl_rad = longint'(val[CW-2:0]);
			CFG_BOTTOM: cyl_bot = longint'(signed'(val));
			CFG_TOP: cyl_top = longint'(signed'(val));
			default: ;
		endcase
	endtask

	task automatic load_cylinder(logic [CW-1:0] r, logic [CW-1:0] b, logic [CW-1:0] t);
		in_valid <= 1'b0;
		@(posedge clk);
		while (hits_due.size() != 0)
			@(posedge clk);
		write_reg(CFG_RADIUS, r);
		write_reg(CFG_BOTTOM, b);
		write_reg(CFG_TOP, t);
		cfg_wr_en <= 1'b0;
	endtask

	// one point transfer; expectation queued when it is taken
	task automatic send_point(coord_t x, coord_t y, coord_t z, umag_t m, bit typed,
			surf_hit_t hit);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		margin <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		hits_due.push_back(typed ? hit : project_point(x, y, z, m));
	endtask

	function automatic coord_t rand_coord();
		return coord_t'(signed'($urandom) >>> $urandom_range(0, 31));
	endfunction

	// point spread over all bits, or placed near the walls and caps
	task automatic send_random_point();
		coord_t x, y, z;
		umag_t m;
		longint zz;
		surf_hit_t none;
		none = '{default: '0};
		if ($urandom_range(0, 3) == 0) begin
			x = coord_t'($urandom);
			y = coord_t'($urandom);
			z = coord_t'($urandom);
			m = umag_t'($urandom);
		end else begin
			x = coord_t'((cyl_rad >> $urandom_range(0, 2)) - longint'($urandom_range(0, 1)
				* 2 * (cyl_rad >> $urandom_range(0, 2))) + ($urandom_range(0, 7) - 3));
			y = ($urandom_range(0, 1)) ? rand_coord() : coord_t'(cyl_rad >> $urandom_range(0, 30));
			if ($urandom_range(0, 1))
				x = rand_coord();
			case ($urandom_range(0, 3))
				0: zz = cyl_bot + $urandom_range(0, 200) - 100;
				1: zz = cyl_top + $urandom_range(0, 200) - 100;
				2: zz = cyl_bot + ((cyl_top - cyl_bot) >>> 1) + rand_coord() / 4;
				default: zz = rand_coord();
			endcase
			z = zz[CW-1:0];
			m = umag_t'(cyl_rad >> $urandom_range(0, 31));
			if ($urandom_range(0, 3) == 0)
				m = umag_t'($urandom >> $urandom_range(1, 31));
		end
		send_point(x, y, z, m, 0, none);
	endtask

	// result check against the oldest expectation
	always @(posedge clk) begin
		surf_hit_t e;
		bit bad;
		if (arst_n && out_valid && out_ready) begin
			if (hits_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing expected: %0d %0d %h %h %h",
						is_inside, fully_inside, proj_x, proj_y, proj_z);
			end else begin
				e = hits_due.pop_front();
				bad = e.is_inside !== is_inside || e.fully_inside !== fully_inside ||
					e.px !== proj_x || e.py !== proj_y || e.pz !== proj_z;
				if (bad) begin
					errors++;
					if (errors <= 10)
						$display("expected %0d %0d %h %h %h, got %0d %0d %h %h %h",
							e.is_inside, e.fully_inside, e.px, e.py, e.pz,
							is_inside, fully_inside, proj_x, proj_y, proj_z);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("cylinder_containment_and_projection: mismatch");
			$finish;
		end
	end

	initial begin
		longint a, b, t;
		surf_hit_t none;
		none = '{default: '0};
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_RADIUS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		margin <= '0;
		out_ready <= 1'b0;
		cyl_rad = 0;
		cyl_bot = 0;
		cyl_top = 0;
		send_idle = 19;
		recv_idle = 61;

		// directed points; typed hits where they are obvious
		rows[0] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, '{1, 1, 0, 0, 0}};
		rows[1] = '{1, 655360, -327680, 327680, 0, 0, 0, 0, 1, '{1, 1, 0, 0, 327680}};
		rows[2] = '{0, 0, 0, 0, 0, 0, 6553600, 0, 1, '{0, 0, 0, 0, 327680}};
		rows[3] = '{0, 0, 0, 0, 0, 0, 0, 31'h7fffffff, 1, '{1, 0, 0, 0, 327680}};
		rows[4] = '{0, 0, 0, 0, 1310720, 0, 0, 0, 1, '{0, 0, 655360, 0, 0}};
		rows[5] = '{0, 0, 0, 0, 196608, 262144, 65536, 65536, 0, none};
		rows[6] = '{0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, none};
		rows[7] = '{0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1, 0, none};
		rows[8] = '{0, 0, 0, 0, 589824, 0, -262144, 131072, 0, none};
		rows[9] = '{1, 32'hffffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, none};
		rows[10] = '{0, 0, 0, 0, 32'h80000000, 0, 0, 31'h7fffffff, 0, none};
		rows[11] = '{0, 0, 0, 0, 0, 0, 32'h80000000, 0, 0, none};
		rows[12] = '{1, 196608, 327680, -327680, 0, 0, 0, 0, 1, '{0, 0, 0, 0, -327680}};
		rows[13] = '{0, 0, 0, 0, 65536, 131072, 458752, 0, 0, none};
		rows[14] = '{0, 0, 0, 0, 0, -6553600, 0, 0, 0, none};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].load_cfg)
				load_cylinder(rows[i].radius, rows[i].bottom, rows[i].top);
			send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].m, rows[i].typed,
				rows[i].hit);
		end

		// random phases, each with its own cylinder; the first two share an idling pattern
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p * 3 / RAND_PHASES)
				0: begin send_idle = 19; recv_idle = 61; end
				1: begin send_idle = 61; recv_idle = 19; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			a = longint'(rand_coord());
			b = longint'(rand_coord());
			if (a > b && $urandom_range(0, 7) != 0) begin
				t = a;
				a = b;
				b = t;
			end
			load_cylinder(($urandom_range(0, 3) == 0) ? $urandom : $urandom >> $urandom_range(8, 24),
				a[CW-1:0], b[CW-1:0]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_random_point();
		end
		in_valid <= 1'b0;

		while (hits_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("cylinder_containment_and_projection: match");
		else
			$display("cylinder_containment_and_projection: mismatch");
		$finish;
	end

endmodule
